// ===== rtl/complex_fixed_point_alu_core_defines.svh =====
// Assertion macros for the complex fixed-point ALU core.
// The core's top level includes this file; it depends on nothing else.
`ifndef COMPLEX_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFPA_ASSERT_SAME(lbl, ante, cons, msg)
`define CFPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cfpa_pkg.sv =====
// Shared constants, opcodes and pipeline types of the complex fixed-point ALU.
// Used by the front stages, the divide/root cells and the top level.
`timescale 1ns / 1ps
package cfpa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = 64;             // magnitudes of products and sums
  localparam int Q_W       = DATA_W + 1;     // quotient bits kept per division
  localparam int N_CELLS   = Q_W;            // one quotient bit and one root bit per cell
  localparam int RAD_W     = 2 * N_CELLS;    // radicand, two bits used per cell
  localparam int ROOT_W    = N_CELLS;
  localparam int SQREM_W   = DATA_W + 3;
  localparam int TOL_W     = 31;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_MOD = 3'd4;
  localparam logic [2:0] CMD_EQ  = 3'd5;
  localparam logic [2:0] CMD_NEG = 3'd6;

  // Sideband that travels with each word along the whole pipeline.
  typedef struct packed {
    logic [2:0]       cmd;
    logic             eq;
    logic             dz;
    logic             sat_re;
    logic             sat_im;
    logic             neg_re;
    logic             neg_im;
    logic [NUM_W-1:0] mag_re;
    logic [NUM_W-1:0] mag_im;
  } side_t;

  // Working state of the two division lanes and the square root.
  typedef struct packed {
    logic [NUM_W-1:0]   den;
    logic [NUM_W-1:0]   rem_re;
    logic [NUM_W-1:0]   rem_im;
    logic [Q_W-1:0]     nq_re;
    logic [Q_W-1:0]     nq_im;
    logic [RAD_W-1:0]   rad;
    logic [SQREM_W-1:0] srem;
    logic [ROOT_W-1:0]  root;
  } cell_t;

endpackage

// ===== rtl/complex_fixed_point_alu_core.sv =====
// Complex-number ALU in signed Q16.16: add, subtract, multiply, divide,
// modulus, equality within a tolerance, and negate.
// Input channel: in_valid/in_stall with cmd and the operands a and b. A word is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with the result parts and three flags.
// Every input word gives exactly one output word, in order.
// The pipeline has three front stages (products, sums, set-up), 33 cells
// of the divide and square-root chain, and the output register. The chain
// handles one new word per cycle while the output is not stalled.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped. The user must write the
// tolerance register (cfg_wr_en/cfg_wr_data) only while the block is idle; the
// block does not enforce it. Synchronous reset empties the pipeline and clears
// the tolerance. Depends on cfpa_pkg, cfpa_front, cfpa_cell and the defines header.
`timescale 1ns / 1ps
`include "complex_fixed_point_alu_core_defines.svh"
module complex_fixed_point_alu_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [cfpa_pkg::TOL_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 cmd,
  input  logic signed [31:0]         a_re,
  input  logic signed [31:0]         a_im,
  input  logic signed [31:0]         b_re,
  input  logic signed [31:0]         b_im,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         res_re,
  output logic signed [31:0]         res_im,
  output logic                       is_equal,
  output logic                       div_zero,
  output logic                       overflow
);
  import cfpa_pkg::*;

  logic             adv;
  logic [TOL_W-1:0] tol;
  logic             cell_valid [N_CELLS+1];
  side_t            cell_side  [N_CELLS+1];
  cell_t            cell_data  [N_CELLS+1];

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  cfpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .tol       (tol),
    .out_valid (cell_valid[0]),
    .out_side  (cell_side[0]),
    .out_cell  (cell_data[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    cfpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (cell_valid[i]),
      .in_side   (cell_side[i]),
      .in_cell   (cell_data[i]),
      .out_valid (cell_valid[i+1]),
      .out_side  (cell_side[i+1]),
      .out_cell  (cell_data[i+1])
    );
  end

  // Returns {overflow, value} for a sign and magnitude.
  function automatic logic [DATA_W:0] sat32(input logic neg, input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0] pos_max;
    logic [NUM_W-1:0] neg_mag;
    pos_max = NUM_W'(64'h7FFF_FFFF);
    neg_mag = NUM_W'(64'h8000_0000);
    if (!neg) begin
      if (mag > pos_max) begin
        sat32 = {1'b1, 32'h7FFF_FFFF};
      end else begin
        sat32 = {1'b0, mag[DATA_W-1:0]};
      end
    end else begin
      if (mag > neg_mag) begin
        sat32 = {1'b1, 32'h8000_0000};
      end else begin
        sat32 = {1'b0, DATA_W'(NUM_W'(0) - mag)};
      end
    end
  endfunction

  side_t            fin;
  cell_t            fcell;
  logic             neg_re, neg_im;
  logic [NUM_W-1:0] mag_re, mag_im;
  logic [DATA_W:0]  r_re, r_im;

  always_comb begin
    fin   = cell_side[N_CELLS];
    fcell = cell_data[N_CELLS];
    case (fin.cmd)
      CMD_DIV: begin
        neg_re = fin.neg_re;
        neg_im = fin.neg_im;
        mag_re = fin.sat_re ? '1 : NUM_W'(fcell.nq_re);
        mag_im = fin.sat_im ? '1 : NUM_W'(fcell.nq_im);
      end
      CMD_MOD: begin
        neg_re = 1'b0;
        neg_im = 1'b0;
        mag_re = NUM_W'(fcell.root);
        mag_im = '0;
      end
      default: begin
        neg_re = fin.neg_re;
        neg_im = fin.neg_im;
        mag_re = fin.mag_re;
        mag_im = fin.mag_im;
      end
    endcase
    r_re = sat32(neg_re, mag_re);
    r_im = sat32(neg_im, mag_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cell_valid[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re   <= r_re[DATA_W-1:0];
      res_im   <= r_im[DATA_W-1:0];
      is_equal <= fin.eq;
      div_zero <= fin.dz;
      overflow <= r_re[DATA_W] | r_im[DATA_W];
    end
  end

  `CFPA_ASSERT_SAME(a_dz_ovf, out_valid && div_zero, overflow, "zero divisor without overflow")
  `CFPA_ASSERT_SAME(a_eq_clean, out_valid && is_equal, res_re == 0 && res_im == 0 && !overflow && !div_zero, "equal word carries a result")
  `CFPA_ASSERT_SAME(a_out_src, $rose(out_valid), $past(cell_valid[N_CELLS]), "output word without a word in the last cell")

endmodule

// ===== rtl/cfpa_front.sv =====
// Front stages of the complex fixed-point ALU: products, sums and cell set-up.
// Depends on cfpa_pkg.
`timescale 1ns / 1ps
module cfpa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [2:0]                     cmd,
  input  logic signed [31:0]             a_re,
  input  logic signed [31:0]             a_im,
  input  logic signed [31:0]             b_re,
  input  logic signed [31:0]             b_im,
  input  logic [cfpa_pkg::TOL_W-1:0]     tol,
  output logic                           out_valid,
  output cfpa_pkg::side_t                out_side,
  output cfpa_pkg::cell_t                out_cell
);
  import cfpa_pkg::*;

  // Stage 1: simple operations, equality and the six multipliers.
  logic [32:0]        ar33, ai33, br33, bi33;
  logic [32:0]        s_re, s_im, d_re, d_im, m_re, m_im, dm_re, dm_im;
  logic [31:0]        ox0, ox1, mx0, mx1;
  logic signed [63:0] c_rr, c_ii, c_ri, c_ir;
  logic [63:0]        c_sq0, c_sq1;
  side_t              side1_next;

  logic               s1_valid;
  side_t              s1_side;
  logic               s1_an_re, s1_an_im;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic [63:0]        sq0, sq1;

  always_comb begin
    ar33 = {a_re[31], a_re};
    ai33 = {a_im[31], a_im};
    br33 = {b_re[31], b_re};
    bi33 = {b_im[31], b_im};
    case (cmd)
      CMD_ADD: begin
        s_re = ar33 + br33;
        s_im = ai33 + bi33;
      end
      CMD_SUB: begin
        s_re = ar33 - br33;
        s_im = ai33 - bi33;
      end
      CMD_NEG: begin
        s_re = 33'd0 - ar33;
        s_im = 33'd0 - ai33;
      end
      default: begin
        s_re = 33'd0;
        s_im = 33'd0;
      end
    endcase
    m_re  = s_re[32] ? 33'd0 - s_re : s_re;
    m_im  = s_im[32] ? 33'd0 - s_im : s_im;
    d_re  = ar33 - br33;
    d_im  = ai33 - bi33;
    dm_re = d_re[32] ? 33'd0 - d_re : d_re;
    dm_im = d_im[32] ? 33'd0 - d_im : d_im;

    side1_next        = '0;
    side1_next.cmd    = cmd;
    side1_next.neg_re = s_re[32];
    side1_next.neg_im = s_im[32];
    side1_next.mag_re = NUM_W'(m_re);
    side1_next.mag_im = NUM_W'(m_im);
    side1_next.eq     = (cmd == CMD_EQ) && (dm_re <= 33'(tol)) && (dm_im <= 33'(tol));

    // The squares feed the divisor for divide and the radicand for modulus.
    ox0   = (cmd == CMD_MOD) ? a_re : b_re;
    ox1   = (cmd == CMD_MOD) ? a_im : b_im;
    mx0   = ox0[31] ? 32'd0 - ox0 : ox0;
    mx1   = ox1[31] ? 32'd0 - ox1 : ox1;
    c_sq0 = 64'(mx0) * 64'(mx0);
    c_sq1 = 64'(mx1) * 64'(mx1);
    c_rr  = a_re * b_re;
    c_ii  = a_im * b_im;
    c_ri  = a_re * b_im;
    c_ir  = a_im * b_re;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side  <= side1_next;
      s1_an_re <= a_re[31];
      s1_an_im <= a_im[31];
      p_rr     <= c_rr;
      p_ii     <= c_ii;
      p_ri     <= c_ri;
      p_ir     <= c_ir;
      sq0      <= c_sq0;
      sq1      <= c_sq1;
    end
  end

  // Stage 2: combine the products into signed sums and take magnitudes.
  logic [64:0]      e_rr, e_ii, e_ri, e_ir, t_re, t_im, u_re, u_im;
  side_t            side2_next;

  logic             s2_valid;
  side_t            s2_side;
  logic             s2_an_re, s2_an_im;
  logic [NUM_W-1:0] num_re, num_im, sqsum;

  always_comb begin
    e_rr = {p_rr[63], p_rr};
    e_ii = {p_ii[63], p_ii};
    e_ri = {p_ri[63], p_ri};
    e_ir = {p_ir[63], p_ir};
    if (s1_side.cmd == CMD_DIV) begin
      t_re = e_rr + e_ii;
      t_im = e_ir - e_ri;
    end else begin
      t_re = e_rr - e_ii;
      t_im = e_ri + e_ir;
    end
    u_re = t_re[64] ? 65'd0 - t_re : t_re;
    u_im = t_im[64] ? 65'd0 - t_im : t_im;

    side2_next = s1_side;
    if (s1_side.cmd == CMD_MUL) begin
      side2_next.neg_re = t_re[64];
      side2_next.neg_im = t_im[64];
      side2_next.mag_re = u_re[NUM_W-1:0] >> FRAC_BITS;
      side2_next.mag_im = u_im[NUM_W-1:0] >> FRAC_BITS;
    end else if (s1_side.cmd == CMD_DIV) begin
      side2_next.neg_re = t_re[64];
      side2_next.neg_im = t_im[64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side  <= side2_next;
      s2_an_re <= s1_an_re;
      s2_an_im <= s1_an_im;
      num_re   <= u_re[NUM_W-1:0];
      num_im   <= u_im[NUM_W-1:0];
      sqsum    <= sq0 + sq1;
    end
  end

  // Stage 3: zero divisor, out-of-range quotients and the first cell's state.
  logic [NUM_W+FRAC_BITS-1:0] n_re, n_im;
  logic [NUM_W+Q_W-1:0]       den_sh;
  logic                       is_div, den_zero;
  side_t                      side3_next;
  cell_t                      cell3_next;

  always_comb begin
    is_div   = (s2_side.cmd == CMD_DIV);
    den_zero = (sqsum == '0);
    n_re     = {num_re, {FRAC_BITS{1'b0}}};
    n_im     = {num_im, {FRAC_BITS{1'b0}}};
    den_sh   = {sqsum, {Q_W{1'b0}}};

    side3_next        = s2_side;
    side3_next.dz     = is_div && den_zero;
    // A quotient of 2^Q_W or more saturates whatever its sign.
    side3_next.sat_re = is_div && (den_zero || ((NUM_W+Q_W)'(n_re) >= den_sh));
    side3_next.sat_im = is_div && (den_zero || ((NUM_W+Q_W)'(n_im) >= den_sh));
    if (is_div && den_zero) begin
      side3_next.neg_re = s2_an_re;
      side3_next.neg_im = s2_an_im;
    end

    cell3_next        = '0;
    cell3_next.den    = sqsum;
    cell3_next.rem_re = NUM_W'(n_re >> Q_W);
    cell3_next.rem_im = NUM_W'(n_im >> Q_W);
    cell3_next.nq_re  = n_re[Q_W-1:0];
    cell3_next.nq_im  = n_im[Q_W-1:0];
    cell3_next.rad    = RAD_W'(sqsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side3_next;
      out_cell <= cell3_next;
    end
  end

endmodule

// ===== rtl/cfpa_cell.sv =====
// One cell of the divide and square-root chain: one quotient bit per lane
// and one root bit per word. Depends on cfpa_pkg.
`timescale 1ns / 1ps
module cfpa_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cfpa_pkg::side_t  in_side,
  input  cfpa_pkg::cell_t  in_cell,
  output logic             out_valid,
  output cfpa_pkg::side_t  out_side,
  output cfpa_pkg::cell_t  out_cell
);
  import cfpa_pkg::*;

  logic [NUM_W:0]     t_re, t_im, den_x;
  logic               ge_re, ge_im, ge_sq;
  logic [SQREM_W+1:0] t_sq, trial;
  cell_t              cell_next;

  always_comb begin
    // Restoring division: the next numerator bit leaves the top of nq while
    // the new quotient bit enters at the bottom.
    den_x = {1'b0, in_cell.den};
    t_re  = {in_cell.rem_re, in_cell.nq_re[Q_W-1]};
    t_im  = {in_cell.rem_im, in_cell.nq_im[Q_W-1]};
    ge_re = (t_re >= den_x);
    ge_im = (t_im >= den_x);

    t_sq  = {in_cell.srem, in_cell.rad[RAD_W-1 -: 2]};
    trial = (SQREM_W+2)'({in_cell.root, 2'b01});
    ge_sq = (t_sq >= trial);

    cell_next        = in_cell;
    cell_next.rem_re = ge_re ? NUM_W'(t_re - den_x) : NUM_W'(t_re);
    cell_next.rem_im = ge_im ? NUM_W'(t_im - den_x) : NUM_W'(t_im);
    cell_next.nq_re  = {in_cell.nq_re[Q_W-2:0], ge_re};
    cell_next.nq_im  = {in_cell.nq_im[Q_W-2:0], ge_im};
    cell_next.srem   = ge_sq ? SQREM_W'(t_sq - trial) : SQREM_W'(t_sq);
    cell_next.root   = {in_cell.root[ROOT_W-2:0], ge_sq};
    cell_next.rad    = {in_cell.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_cell <= cell_next;
    end
  end

endmodule
